// ===== rtl/core/lrfv_pkg.sv =====
// Shared types and constants for the linear resampler with frame voice detection.
package lrfv_pkg;

  localparam int FRAME_LEN_DEF = 160;
  localparam int MAX_OUT       = 4;

  localparam int SAMPLE_W  = 20;
  localparam int PCM_W     = 16;
  localparam int PHASE_W   = 20;
  localparam int INV_W     = 19;
  localparam int THR_W     = 32;
  localparam int ENERGY_W  = 51;
  localparam int COUNT_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // bit-serial multiplier: A is parallel, B is consumed one bit per cycle
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 21;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = $clog2(MUL_BW);

  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RATIO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VAD_THR    = 2'd2;

  localparam logic [PHASE_W-1:0] STEP_RESET = 20'd65536;
  localparam logic [INV_W-1:0]   INV_RESET  = 19'd65536;
  localparam logic [THR_W-1:0]   THR_RESET  = 32'd26844;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_TMUL = 7'b0001000,
    S_IMUL = 7'b0010000,
    S_VMUL = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

endpackage

// ===== rtl/core/lrfv_mul.sv =====
// Shift-add unsigned multiplier, one multiplier bit per cycle.
module lrfv_mul import lrfv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [MUL_PW-1:0] a_sh_r, a_sh_nxt;
  logic [MUL_BW-1:0] b_r, b_nxt;
  logic [MUL_PW-1:0] acc_r, acc_nxt;
  logic [MUL_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  always_comb begin
    a_sh_nxt = a_sh_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_sh_nxt = MUL_PW'(req.a);
      b_nxt    = req.b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_sh_r;
      a_sh_nxt = a_sh_r << 1;
      b_nxt    = b_r >> 1;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == MUL_CW'(MUL_BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_sh_r <= a_sh_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== rtl/core/linear_resampler_frame_vad_unit.sv =====
// Top level: linear-interpolation resampler with frame energy and voice activity flag.
// Each input sample takes one bit-serial multiply for its square plus control states;
// each result it causes takes two more multiplies (interpolation fraction and
// interpolation), and a third one at a frame end for the threshold product, plus any
// output stall. All products go through one shared shift-add multiplier that
// retires one bit per cycle, so that multiplier sets the pace. One input is handled
// at a time; up to four results per input, the last one flagged by out_last_result.
module linear_resampler_frame_vad_unit import lrfv_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [PCM_W-1:0]    out_pcm_out,
  output logic                       out_frame_end,
  output logic [ENERGY_W-1:0]        out_energy_sum,
  output logic [COUNT_W-1:0]         out_energy_count,
  output logic                       out_voice_active,
  output logic                       out_voice_changed,
  output logic                       out_last_result
);

  localparam int POS_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

  state_t state_r, state_nxt;

  logic [PHASE_W-1:0]  step_r;
  logic [INV_W-1:0]    inv_r;
  logic [THR_W-1:0]    thr_r;

  logic signed [SAMPLE_W-1:0] s_r, s_nxt, prev_r, prev_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [COUNT_W-1:0]  ecnt_r, ecnt_nxt;
  logic                prior_r, prior_nxt;
  logic [2:0]          n_r, n_nxt;
  logic                dneg_r, dneg_nxt;

  logic signed [PCM_W-1:0] pcm_r, pcm_nxt;
  logic                fe_r, fe_nxt;
  logic [ENERGY_W-1:0] esum_r, esum_nxt;
  logic [COUNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic                va_r, va_nxt;
  logic                vc_r, vc_nxt;
  logic                last_r, last_nxt;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  lrfv_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // datapath helpers
  logic [SAMPLE_W-1:0]     in_mag;
  logic [ENERGY_W:0]       esum_wide;
  logic [PHASE_W:0]        phase_inc;
  logic [MUL_PW-17:0]      t_raw;
  logic [16:0]             t_q;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]       diff_mag;
  logic signed [MUL_PW:0]  prod_s;
  logic signed [MUL_PW:0]  prod_rnd;
  logic signed [MUL_PW-16:0] quot;
  logic signed [MUL_PW-16:0] interp;
  logic signed [16:0]      clip;
  logic signed [33:0]      scaled;
  logic signed [33:0]      scaled_adj;
  logic [POS_W:0]          pos_inc;
  logic                    frame_done;
  logic                    vad;

  assign in_mag    = in_sample_in[SAMPLE_W-1] ? SAMPLE_W'(-in_sample_in)
                                              : SAMPLE_W'(in_sample_in);
  assign esum_wide = {1'b0, energy_r} + (ENERGY_W+1)'(mrsp.prod[2*SAMPLE_W-1:0]);
  assign phase_inc = {1'b0, phase_r} + (PHASE_W+1)'(20'h10000);
  assign t_raw     = mrsp.prod[MUL_PW-1:16];
  assign t_q       = (t_raw > (MUL_PW-16)'(17'h10000)) ? 17'h10000 : t_raw[16:0];
  assign diff      = {s_r[SAMPLE_W-1], s_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign diff_mag  = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
  assign prod_s    = dneg_r ? -$signed({1'b0, mrsp.prod}) : $signed({1'b0, mrsp.prod});
  assign prod_rnd  = prod_s + (MUL_PW+1)'(32768);
  assign quot      = prod_rnd[MUL_PW:16];   // floor divide by 65536
  assign interp    = quot + (MUL_PW-15)'(prev_r);

  always_comb begin
    if (interp < -(MUL_PW-15)'(32768))     clip = -17'sd32768;
    else if (interp > (MUL_PW-15)'(32768)) clip = 17'sd32768;
    else                                   clip = interp[16:0];
  end

  // clip * 32767 / 32768, truncated toward zero
  assign scaled     = (34'(clip) <<< 15) - 34'(clip);
  assign scaled_adj = scaled[33] ? scaled + 34'sd32767 : scaled;

  assign pos_inc    = {1'b0, pos_r} + 1'b1;
  assign frame_done = (pos_inc >= (POS_W+1)'(FRAME_LEN));
  assign vad        = ({2'b0, energy_r} > mrsp.prod);

  always_comb begin
    state_nxt  = state_r;
    s_nxt      = s_r;
    prev_nxt   = prev_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    energy_nxt = energy_r;
    ecnt_nxt   = ecnt_r;
    prior_nxt  = prior_r;
    n_nxt      = n_r;
    dneg_nxt   = dneg_r;
    pcm_nxt    = pcm_r;
    fe_nxt     = fe_r;
    esum_nxt   = esum_r;
    ocnt_nxt   = ocnt_r;
    va_nxt     = va_r;
    vc_nxt     = vc_r;
    last_nxt   = last_r;
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          s_nxt      = in_sample_in;
          mreq.start = 1'b1;
          mreq.a     = MUL_AW'(in_mag);
          mreq.b     = MUL_BW'(in_mag);
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        if (mrsp.done) begin
          energy_nxt = esum_wide[ENERGY_W] ? {ENERGY_W{1'b1}} : esum_wide[ENERGY_W-1:0];
          if (ecnt_r != {COUNT_W{1'b1}}) ecnt_nxt = ecnt_r + 1'b1;
          phase_nxt  = phase_inc[PHASE_W] ? {PHASE_W{1'b1}} : phase_inc[PHASE_W-1:0];
          n_nxt      = '0;
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        if (n_r != 3'(MAX_OUT) && phase_r >= step_r) begin
          phase_nxt  = phase_r - step_r;
          mreq.start = 1'b1;
          mreq.a     = MUL_AW'(inv_r);
          mreq.b     = MUL_BW'(phase_r - step_r);
          state_nxt  = S_TMUL;
        end else begin
          prev_nxt  = s_r;
          state_nxt = S_IDLE;
        end
      end
      S_TMUL: begin
        if (mrsp.done) begin
          dneg_nxt   = diff[SAMPLE_W];
          mreq.start = 1'b1;
          mreq.a     = MUL_AW'(t_q);
          mreq.b     = MUL_BW'(diff_mag);
          state_nxt  = S_IMUL;
        end
      end
      S_IMUL: begin
        if (mrsp.done) begin
          pcm_nxt  = scaled_adj[30:15];
          last_nxt = (n_r == 3'(MAX_OUT - 1)) || (phase_r < step_r);
          fe_nxt   = 1'b0;
          esum_nxt = '0;
          ocnt_nxt = '0;
          va_nxt   = 1'b0;
          vc_nxt   = 1'b0;
          if (frame_done) begin
            mreq.start = 1'b1;
            mreq.a     = MUL_AW'(thr_r);
            mreq.b     = MUL_BW'(ecnt_r);
            state_nxt  = S_VMUL;
          end else begin
            pos_nxt   = pos_inc[POS_W-1:0];
            state_nxt = S_OUT;
          end
        end
      end
      S_VMUL: begin
        if (mrsp.done) begin
          fe_nxt     = 1'b1;
          esum_nxt   = energy_r;
          ocnt_nxt   = ecnt_r;
          va_nxt     = vad;
          vc_nxt     = (vad != prior_r);
          prior_nxt  = vad;
          energy_nxt = '0;
          ecnt_nxt   = '0;
          pos_nxt    = '0;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_CHK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= STEP_RESET;
      inv_r    <= INV_RESET;
      thr_r    <= THR_RESET;
      prev_r   <= '0;
      phase_r  <= '0;
      pos_r    <= '0;
      energy_r <= '0;
      ecnt_r   <= '0;
      prior_r  <= 1'b0;
      n_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      prev_r   <= prev_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      energy_r <= energy_nxt;
      ecnt_r   <= ecnt_nxt;
      prior_r  <= prior_nxt;
      n_r      <= n_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP_RATIO: step_r <= cfg_wdata[PHASE_W-1:0];
          REG_INV_RATIO:  inv_r  <= cfg_wdata[INV_W-1:0];
          REG_VAD_THR:    thr_r  <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
    end
    s_r    <= s_nxt;
    dneg_r <= dneg_nxt;
    pcm_r  <= pcm_nxt;
    fe_r   <= fe_nxt;
    esum_r <= esum_nxt;
    ocnt_r <= ocnt_nxt;
    va_r   <= va_nxt;
    vc_r   <= vc_nxt;
    last_r <= last_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_pcm_out       = pcm_r;
  assign out_frame_end     = fe_r;
  assign out_energy_sum    = esum_r;
  assign out_energy_count  = ocnt_r;
  assign out_voice_active  = va_r;
  assign out_voice_changed = vc_r;
  assign out_last_result   = last_r;

endmodule
